// ===== sv/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg
// shared widths and request codes for the rotated sorted search block
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int VALUE_W    = 32;
    localparam int OP_W       = 2;
    localparam int POS_W      = 10;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

endpackage

// ===== sv/rotated_sorted_search.sv =====
// ----------------------------------------------------------------------------
// rotated_sorted_search
// search in a rotated ascending array held in a single-port element ram
// ----------------------------------------------------------------------------
// channel  | dir | tdata (low bit up)        | tuser (low bit up)
// s_axis   | in  | value [31:0]              | operation [1:0]
// m_axis   | out | position [9:0], zero pad  | found [0]
//
// clear and append requests are handled in the idle state; other codes are dropped
// a search bisects for the pivot, checks the pivot and the first entry, then
// runs a binary search over the half that can hold the target, or over the
// whole array when no pivot is found, with all reads on the one ram port
// no clearing pass after reset: the element count alone marks valid entries
// a finished result waits in the output register while new requests enter
// ----------------------------------------------------------------------------
module rotated_sorted_search import rss_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VALUE_W-1:0]    s_axis_tdata,  // value
    input  logic [OP_W-1:0]       s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // position, zero pad
    output logic                  m_axis_tuser   // found
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PV_CHK,
        ST_PV_MID,
        ST_PV_NXT,
        ST_PV_PRV,
        ST_PV_LO,
        ST_PF_PIV,
        ST_PF_FST,
        ST_PF_CMP,
        ST_BS_CHK,
        ST_BS_CMP,
        ST_OUT
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic signed [IW-1:0]       r_lo;
    logic signed [IW-1:0]       r_hi;
    logic signed [IW-1:0]       r_mid;
    logic signed [VALUE_W-1:0]  r_target;
    logic signed [VALUE_W-1:0]  r_vmid;
    logic signed [VALUE_W-1:0]  r_vnext;
    logic signed [VALUE_W-1:0]  r_vprev;
    logic                       r_found;
    logic [IW-1:0]              r_pos;
    logic                       r_m_valid;
    logic                       r_m_found;
    logic [POS_W-1:0]           r_m_pos;

    t_op                        op;
    logic                       acc;
    logic                       out_load;
    logic signed [IW:0]         mid_sum;
    logic signed [IW-1:0]       mid_c;
    logic signed [IW-1:0]       last_c;
    logic signed [IW-1:0]       addr_c;
    logic                       ram_we;
    logic signed [VALUE_W-1:0]  rd;
    logic [IW+POS_W-1:0]        pos_ext;

    assign op            = t_op'(s_axis_tuser);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);
    assign mid_sum       = {r_lo[IW-1], r_lo} + {r_hi[IW-1], r_hi};
    assign mid_c         = mid_sum[IW:1];
    assign last_c        = $signed({1'b0, r_count}) - IW'(1);
    assign ram_we        = acc && (op == OP_APPEND) && (r_count < CW'(DEPTH));
    assign pos_ext       = {{POS_W{1'b0}}, r_pos};

    always_comb begin
        case (r_state)
            ST_IDLE:   addr_c = $signed({1'b0, r_count});
            ST_PV_CHK: addr_c = mid_c;
            ST_BS_CHK: addr_c = mid_c;
            ST_PV_MID: addr_c = r_mid + IW'(1);
            ST_PV_NXT: addr_c = r_mid - IW'(1);
            ST_PV_PRV: addr_c = r_lo;
            ST_PF_FST: addr_c = '0;
            default:   addr_c = r_mid;
        endcase
    end

    rss_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (addr_c[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        case (op)
                            OP_CLEAR: begin
                                r_count <= '0;
                            end
                            OP_APPEND: begin
                                if (r_count < CW'(DEPTH)) begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_SEARCH: begin
                                r_target <= s_axis_tdata;
                                r_lo     <= '0;
                                r_hi     <= last_c;
                                r_state  <= ST_PV_CHK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_PV_CHK: begin
                    if (r_lo > r_hi) begin
                        r_lo    <= '0;
                        r_hi    <= last_c;
                        r_state <= ST_BS_CHK;
                    end else if (r_lo == r_hi) begin
                        r_mid   <= r_hi;
                        r_state <= ST_PF_PIV;
                    end else begin
                        r_mid   <= mid_c;
                        r_state <= ST_PV_MID;
                    end
                end
                ST_PV_MID: begin
                    r_vmid  <= rd;
                    r_state <= ST_PV_NXT;
                end
                ST_PV_NXT: begin
                    r_vnext <= rd;
                    r_state <= ST_PV_PRV;
                end
                ST_PV_PRV: begin
                    r_vprev <= rd;
                    r_state <= ST_PV_LO;
                end
                ST_PV_LO: begin
                    if ((r_mid < r_hi) && (r_vmid > r_vnext)) begin
                        r_state <= ST_PF_PIV;
                    end else if ((r_mid > r_lo) && (r_vmid < r_vprev)) begin
                        r_mid   <= r_mid - IW'(1);
                        r_state <= ST_PF_PIV;
                    end else if (rd > r_vmid) begin
                        r_hi    <= r_mid - IW'(1);
                        r_state <= ST_PV_CHK;
                    end else begin
                        r_lo    <= r_mid + IW'(1);
                        r_state <= ST_PV_CHK;
                    end
                end
                ST_PF_PIV: begin
                    r_state <= ST_PF_FST;
                end
                ST_PF_FST: begin
                    r_vmid  <= rd;
                    r_state <= ST_PF_CMP;
                end
                ST_PF_CMP: begin
                    if (r_vmid == r_target) begin
                        r_found <= 1'b1;
                        r_pos   <= r_mid;
                        r_state <= ST_OUT;
                    end else if (rd > r_target) begin
                        r_lo    <= r_mid + IW'(1);
                        r_hi    <= last_c;
                        r_state <= ST_BS_CHK;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= r_mid - IW'(1);
                        r_state <= ST_BS_CHK;
                    end
                end
                ST_BS_CHK: begin
                    if (r_lo > r_hi) begin
                        r_found <= 1'b0;
                        r_pos   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_mid   <= mid_c;
                        r_state <= ST_BS_CMP;
                    end
                end
                ST_BS_CMP: begin
                    if (rd == r_target) begin
                        r_found <= 1'b1;
                        r_pos   <= r_mid;
                        r_state <= ST_OUT;
                    end else if (r_target > rd) begin
                        r_lo    <= r_mid + IW'(1);
                        r_state <= ST_BS_CHK;
                    end else begin
                        r_hi    <= r_mid - IW'(1);
                        r_state <= ST_BS_CHK;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_m_found <= r_found;
                        r_m_pos   <= pos_ext[POS_W-1:0];
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_found;
    assign m_axis_tdata  = {{(OUT_DATA_W-POS_W){1'b0}}, r_m_pos};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_search_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (op == OP_SEARCH)) |=> (r_state == ST_PV_CHK))
        else $error("search request did not start pivot search");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside result state");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (r_m_pos == '0))
        else $error("miss with nonzero position");

endmodule

// ===== sv/rss_ram.sv =====
// ----------------------------------------------------------------------------
// rss_ram
// single-port element ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module rss_ram import rss_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_addr,
    input  logic [VALUE_W-1:0] i_wdata,
    output logic [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// rotated_sorted_search against a cycle-free predictor of the rotated array
// directed extremes, empty, unrotated and single-entry arrays, unused code,
// then random rotated arrays, one full store with appends past capacity,
// malformed arrays and noise; random stalls both sides; in-order result checks
// ----------------------------------------------------------------------------
module testbench import rss_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 1024;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int STIM_TARGET = 1450;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic               hold;
    } t_search_req;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } t_search_res;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata  = '0;    // value
    logic [OP_W-1:0]       s_axis_tuser  = '0;    // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // position, zero pad
    logic                  m_axis_tuser;          // found

    rotated_sorted_search #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    t_search_req requests_todo[$];
    t_search_res results_due[$];
    t_search_req cur_req;
    logic signed [VALUE_W-1:0] loaded_vals[$];

    logic signed [VALUE_W-1:0] elem_mem [DEPTH];
    int elem_cnt    = 0;

    int total_reqs  = 1;
    int n_sent      = 0;
    int n_search    = 0;
    int n_hit       = 0;
    int n_dropped   = 0;
    int n_unused    = 0;
    int n_checked   = 0;
    int n_err       = 0;
    int cycle_cnt   = 0;

    // position of the largest entry in [lo, hi], -1 when the bisection falls through
    function automatic int pivot_index(int lo, int hi);
        int mid;
        while (lo <= hi) begin
            if (lo == hi) begin
                return hi;
            end
            mid = lo + (hi - lo) / 2;
            if (mid < hi && elem_mem[mid] > elem_mem[mid + 1]) begin
                return mid;
            end
            if (mid > lo && elem_mem[mid] < elem_mem[mid - 1]) begin
                return mid - 1;
            end
            if (elem_mem[lo] > elem_mem[mid]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return -1;
    endfunction

    function automatic int bisect_range(int lo, int hi, logic signed [VALUE_W-1:0] target);
        int mid;
        logic signed [VALUE_W-1:0] probe;
        while (lo <= hi) begin
            mid   = lo + (hi - lo) / 2;
            probe = elem_mem[mid];
            if (target == probe) begin
                return mid;
            end
            if (target > probe) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return -1;
    endfunction

    function automatic int locate_target(logic signed [VALUE_W-1:0] target);
        int last;
        int piv;
        last = elem_cnt - 1;
        piv  = pivot_index(0, last);
        if (piv < 0) begin
            return bisect_range(0, last, target);
        end
        if (elem_mem[piv] == target) begin
            return piv;
        end
        if (elem_mem[0] > target) begin
            return bisect_range(piv + 1, last, target);
        end
        return bisect_range(0, piv - 1, target);
    endfunction

    function automatic void absorb_request(t_search_req r);
        int idx;
        t_search_res res;
        n_sent++;
        case (r.op)
            OP_CLEAR: begin
                elem_cnt = 0;
            end
            OP_APPEND: begin
                if (elem_cnt < DEPTH) begin
                    elem_mem[elem_cnt] = r.value;
                    elem_cnt++;
                end else begin
                    n_dropped++;
                end
            end
            OP_SEARCH: begin
                n_search++;
                idx = locate_target(r.value);
                if (idx >= 0) begin
                    n_hit++;
                    res.found = 1'b1;
                    res.pos   = idx[POS_W-1:0];
                end else begin
                    res.found = 1'b0;
                    res.pos   = '0;
                end
                results_due.push_back(res);
            end
            default: begin
                n_unused++;
            end
        endcase
    endfunction

    // percent of cycles a side stays idle: sender first light then heavy, then none
    function automatic int stall_pct(bit rx);
        int ph;
        ph = (n_sent * 3) / total_reqs;
        if (ph == 0) begin
            return rx ? 70 : 7;
        end
        if (ph == 1) begin
            return rx ? 7 : 70;
        end
        return 0;
    endfunction

    task automatic push_req(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value, bit hold = 1'b0);
        t_search_req r;
        r.op    = op;
        r.value = value;
        r.hold  = hold;
        requests_todo.push_back(r);
    endtask

    task automatic load_rotated(int n, bit dense);
        longint step_max;
        longint span_left;
        longint v;
        int rot;
        longint sorted_vals[$];
        push_req(OP_CLEAR, $urandom, ($urandom_range(0, 19) == 0));
        loaded_vals.delete();
        if (n > 0) begin
            step_max  = dense ? 64'd4 : (64'd1 << 32) / (n + 1);
            span_left = (64'd1 << 32) - 1 - (n - 1) * step_max;
            v = -(64'sd1 <<< 31) + longint'($urandom_range(32'(span_left), 0));
            for (int i = 0; i < n; i++) begin
                sorted_vals.push_back(v);
                v = v + longint'($urandom_range(32'(step_max), 1));
            end
            rot = $urandom_range(n - 1, 0);
            for (int i = 0; i < n; i++) begin
                loaded_vals.push_back(32'(sorted_vals[(i + rot) % n]));
                push_req(OP_APPEND, loaded_vals[i]);
            end
        end
    endtask

    task automatic push_searches(int k);
        logic [VALUE_W-1:0] t;
        for (int i = 0; i < k; i++) begin
            if (loaded_vals.size() > 0 && $urandom_range(0, 9) < 6) begin
                t = loaded_vals[$urandom_range(loaded_vals.size() - 1, 0)];
            end else if (loaded_vals.size() > 0 && $urandom_range(0, 1) == 1) begin
                t = loaded_vals[$urandom_range(loaded_vals.size() - 1, 0)]
                    + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
            end else begin
                t = $urandom;
            end
            push_req(OP_SEARCH, t);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_request(cur_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (requests_todo.size() > 0 && $urandom_range(99, 0) >= stall_pct(1'b0)
                    && (!requests_todo[0].hold || results_due.size() == 0)) begin
                    cur_req = requests_todo.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_req.value;
                    s_axis_tuser  <= cur_req.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_search_res want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    if (n_err < MAX_REPORTS) begin
                        $display("%0t: unexpected result: found %0b tdata 0x%04h",
                                 $realtime, m_axis_tuser, m_axis_tdata);
                    end
                    n_err++;
                end else begin
                    want = results_due.pop_front();
                    n_checked++;
                    if (m_axis_tuser !== want.found
                        || m_axis_tdata !== OUT_DATA_W'(want.pos)) begin
                        if (n_err < MAX_REPORTS) begin
                            $display("%0t: result %0d: expected found %0b tdata 0x%04h,",
                                     $realtime, n_checked, want.found,
                                     OUT_DATA_W'(want.pos));
                            $display("    got found %0b tdata 0x%04h",
                                     m_axis_tuser, m_axis_tdata);
                        end
                        n_err++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= stall_pct(1'b1));
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, results_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        int n;
        bit big_done;
        big_done = 1'b0;

        // empty array, extremes, pivot hits on both halves, unused code
        push_req(OP_SEARCH, 32'd0);
        push_req(OP_UNUSED, 32'hFFFF_FFFF);
        push_req(OP_APPEND, 32'd5);
        push_req(OP_APPEND, 32'h7FFF_FFFF);
        push_req(OP_APPEND, 32'h8000_0000);
        push_req(OP_APPEND, 32'hFFFF_FFFF);
        push_req(OP_APPEND, 32'd0);
        push_req(OP_APPEND, 32'd3);
        push_req(OP_SEARCH, 32'h7FFF_FFFF);
        push_req(OP_SEARCH, 32'h8000_0000);
        push_req(OP_SEARCH, 32'd3);
        push_req(OP_SEARCH, 32'd5);
        push_req(OP_SEARCH, 32'd4, 1'b1);
        push_req(OP_SEARCH, 32'hFFFF_FFFE);
        push_req(OP_UNUSED, 32'd0);
        push_req(OP_CLEAR, 32'd0);
        push_req(OP_SEARCH, 32'd5);
        // ascending without rotation
        push_req(OP_APPEND, -32'sd7);
        push_req(OP_APPEND, 32'd1);
        push_req(OP_APPEND, 32'd9);
        push_req(OP_SEARCH, 32'd9);
        push_req(OP_SEARCH, -32'sd7);
        push_req(OP_SEARCH, 32'd2);
        // single element
        push_req(OP_CLEAR, 32'd0);
        push_req(OP_APPEND, 32'd42);
        push_req(OP_SEARCH, 32'd42);

        while (requests_todo.size() < STIM_TARGET) begin
            pick = $urandom_range(99, 0);
            if (!big_done && requests_todo.size() > 400) begin
                // full store, appends past capacity, searches reaching the top positions
                big_done = 1'b1;
                load_rotated(DEPTH, $urandom_range(1, 0));
                for (int i = 0; i < 3; i++) begin
                    push_req(OP_APPEND, $urandom);
                end
                push_searches(16);
            end else if (pick < 80) begin
                n = $urandom_range(99, 0);
                n = (n < 5) ? 0 : (n < 75) ? $urandom_range(16, 1) : $urandom_range(80, 17);
                load_rotated(n, $urandom_range(1, 0));
                push_searches($urandom_range(6, 2));
            end else if (pick < 90) begin
                // malformed array with likely duplicates
                push_req(OP_CLEAR, $urandom);
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++) begin
                    push_req(OP_APPEND, $urandom_range(1, 0) ? $urandom_range(7, 0) : $urandom);
                end
                for (int i = 0; i < 3; i++) begin
                    push_req(OP_SEARCH, $urandom_range(1, 0) ? $urandom_range(7, 0) : $urandom);
                end
            end else begin
                case ($urandom_range(3, 0))
                    0: push_req(OP_APPEND, $urandom);
                    1: push_req(OP_UNUSED, $urandom);
                    2: push_req(OP_CLEAR, $urandom);
                    default: push_req(OP_SEARCH, $urandom);
                endcase
            end
        end
        total_reqs = requests_todo.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_todo.size() > 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (results_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);

        $display("sent %0d requests: %0d searches (%0d hits), %0d appends past capacity,",
                 n_sent, n_search, n_hit, n_dropped);
        $display("%0d unused codes; checked %0d results, %0d mismatches",
                 n_unused, n_checked, n_err);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/rss_pkg.sv
sv/rss_ram.sv
sv/rotated_sorted_search.sv
tb/testbench.sv
